[src/masked_histogram_mean_spread_macros.svh]
// Assertion macros for the masked histogram statistics block.
// Depends on nothing; included by the files that carry assertions.
`ifndef MASKED_HISTOGRAM_MEAN_SPREAD_MACROS_SVH
`define MASKED_HISTOGRAM_MEAN_SPREAD_MACROS_SVH
`ifndef SYNTHESIS
`define MHMS_ASSERT_IMP(name, clk, rst_n, a, c) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("mhms assertion failed");
`define MHMS_ASSERT_NXT(name, clk, rst_n, a, c) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("mhms assertion failed");
`else
`define MHMS_ASSERT_IMP(name, clk, rst_n, a, c)
`define MHMS_ASSERT_NXT(name, clk, rst_n, a, c)
`endif
`endif

[src/mhms_pkg.sv]
// Types, widths and state codes for the masked histogram statistics block.
// No dependencies; used by every module of the block except mhms_ram.
package mhms_pkg;

    localparam int COUNT_BITS   = 24;
    localparam int BIN_COUNT    = 256;
    localparam int BIN_BITS     = $clog2(BIN_COUNT);
    localparam int OUT_CNT_BITS = 24;
    localparam int CMP_BITS     = (COUNT_BITS > OUT_CNT_BITS) ? COUNT_BITS : OUT_CNT_BITS;
    localparam int SUM_BITS     = COUNT_BITS + BIN_BITS;
    localparam int WSUM_BITS    = COUNT_BITS + 2 * BIN_BITS;
    localparam int DEV_BITS     = COUNT_BITS + BIN_BITS;
    localparam int SQR_BITS     = 2 * DEV_BITS;
    localparam int VAR_BITS     = SQR_BITS + BIN_BITS;
    localparam int ROOT_BITS    = (VAR_BITS + 2) / 2;
    localparam int ITER_BITS    = $clog2(ROOT_BITS + 1);
    localparam int DIVD_BITS    = SUM_BITS + 1;
    localparam int DIVN_BITS    = DIVD_BITS + 8;
    localparam int WALK_BITS    = BIN_BITS + 1;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic [7:0] mask_value;
        logic       last_pixel;
    } pixel_item_t;

    typedef struct packed {
        logic [7:0]              mean_level;
        logic [7:0]              spread;
        logic [OUT_CNT_BITS-1:0] pixel_count;
        logic                    empty_frame;
    } stats_item_t;

    typedef struct packed {
        logic                 start;
        logic [DIVN_BITS-1:0] num;
        logic [DIVD_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic                   start;
        logic [2*ROOT_BITS-1:0] value;
    } sqrt_req_t;

    typedef struct packed {
        logic                 done;
        logic [ROOT_BITS-1:0] root;
    } sqrt_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_SUM,
        ST_MEAN_GO,
        ST_MEAN,
        ST_VAR,
        ST_ROOT_GO,
        ST_ROOT,
        ST_SPREAD_GO,
        ST_SPREAD,
        ST_EMIT,
        ST_CLEAR
    } state_t;

    localparam logic ADDR_MASK_ENABLE = 1'b0;

endpackage

[src/mhms_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module mhms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // read during write to the same entry returns the old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/mhms_divider.sv]
// Restoring divider, one quotient bit per cycle, quotient saturated to 8 bits.
// Depends on mhms_pkg.
module mhms_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  mhms_pkg::div_req_t req,
    output mhms_pkg::div_rsp_t rsp
);
    logic [mhms_pkg::DIVN_BITS-1:0] rem_reg, rem_next, shifted;
    logic [mhms_pkg::DIVD_BITS-1:0] den_reg, den_next;
    logic [3:0]                     step_reg, step_next;
    logic [8:0]                     quot_reg, quot_next;
    logic                           active_reg, active_next;
    logic                           done_reg, done_next;
    logic                           fits;

    always_comb
    begin
        shifted     = {den_reg, 8'd0} >> (4'd8 - step_reg);
        fits        = rem_reg >= shifted;
        rem_next    = rem_reg;
        den_next    = den_reg;
        step_next   = step_reg;
        quot_next   = quot_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            rem_next    = req.num;
            den_next    = req.den;
            step_next   = 4'd8;
            quot_next   = '0;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            if (fits)
            begin
                rem_next  = rem_reg - shifted;
                quot_next = quot_reg | (9'd1 << step_reg);
            end
            if (step_reg == 4'd0)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
            else
            begin
                step_next = step_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        step_reg <= step_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg[8] ? 8'hFF : quot_reg[7:0];
endmodule

[src/mhms_isqrt.sv]
// Integer square root (floor), two radicand bits per cycle.
// Depends on mhms_pkg.
module mhms_isqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  mhms_pkg::sqrt_req_t req,
    output mhms_pkg::sqrt_rsp_t rsp
);
    localparam int RB = mhms_pkg::ROOT_BITS;

    logic [2*RB-1:0]                val_reg, val_next;
    logic [RB+2:0]                  rem_reg, rem_next, rem_sh, trial;
    logic [RB-1:0]                  root_reg, root_next;
    logic [mhms_pkg::ITER_BITS-1:0] iter_reg, iter_next;
    logic                           active_reg, active_next;
    logic                           done_reg, done_next;

    always_comb
    begin
        rem_sh      = {rem_reg[RB:0], val_reg[2*RB-1 -: 2]};
        trial       = {1'b0, root_reg, 2'b01};
        val_next    = val_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        iter_next   = iter_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            val_next    = req.value;
            rem_next    = '0;
            root_next   = '0;
            iter_next   = mhms_pkg::ITER_BITS'(RB);
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            val_next = {val_reg[2*RB-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[RB-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[RB-2:0], 1'b0};
            end
            iter_next = iter_reg - 1'b1;
            if (iter_reg == mhms_pkg::ITER_BITS'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        iter_reg <= iter_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;
endmodule

[src/masked_histogram_mean_spread.sv]
// Masked grey-level histogram with end-of-frame mean and spread.
// Throughput: one pixel transaction per cycle while idle. A last pixel holds busy high through
// drain, sum walk, mean divide, variance walk, root (ROOT_BITS steps), spread divide and
// strobe, or only through drain, sum walk and strobe when nothing was counted; the strobe
// comes while busy is still high and the receiver cannot stall it.
// Reset: rst_n asynchronous, active low, then a pass over all 256 bins zeroes them, busy high.
`include "masked_histogram_mean_spread_macros.svh"
module masked_histogram_mean_spread (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mhms_pkg::pixel_item_t pixel_in,
    output logic                  stats_valid,
    output mhms_pkg::stats_item_t stats_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    localparam int CB = mhms_pkg::COUNT_BITS;
    localparam int BB = mhms_pkg::BIN_BITS;

    mhms_pkg::state_t state_reg, state_next;

    // configuration
    logic mask_enable_reg;

    // accept and count
    logic accept, count_en;
    logic [CB-1:0] total_reg, total_next;

    // histogram RAM and the read-modify-write stage
    logic          ram_we;
    logic [BB-1:0] ram_waddr, ram_raddr;
    logic [CB-1:0] ram_wdata, ram_rdata;
    logic          s1_valid_reg;
    logic [BB-1:0] s1_addr_reg;
    logic          lw_valid_reg;
    logic [BB-1:0] lw_addr_reg;
    logic [CB-1:0] lw_data_reg;
    logic [CB-1:0] bin_old, bin_new;

    // walk
    logic [mhms_pkg::WALK_BITS-1:0] walk_reg;
    logic                           walk_issue;
    logic                           clear_we;
    logic                           rd_v_reg, v2_reg, v3_reg;
    logic [BB-1:0]                  rd_k_reg;
    logic [7:0]                     dev;
    logic [mhms_pkg::DEV_BITS-1:0]  t_reg;
    logic [mhms_pkg::SQR_BITS-1:0]  tt_reg;
    logic [mhms_pkg::SUM_BITS-1:0]  s_reg;
    logic [mhms_pkg::WSUM_BITS-1:0] w_reg;
    logic [mhms_pkg::VAR_BITS-1:0]  v_reg;
    logic [mhms_pkg::ROOT_BITS-1:0] root_reg;
    logic [7:0]                     mean_reg, spread_reg;
    logic                           sum_done, var_done;

    // arithmetic units
    mhms_pkg::div_req_t  div_req;
    mhms_pkg::div_rsp_t  div_rsp;
    mhms_pkg::sqrt_req_t sqrt_req;
    mhms_pkg::sqrt_rsp_t sqrt_rsp;
    logic                div_go, sqrt_go;

    // output count clamp
    logic [mhms_pkg::CMP_BITS-1:0] total_ext;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_enable_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[2] == mhms_pkg::ADDR_MASK_ENABLE)
        begin
            mask_enable_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == mhms_pkg::ADDR_MASK_ENABLE) ? {31'd0, mask_enable_reg} : '0;

    // ---------------- pixel acceptance ----------------
    assign accept   = start && !busy;
    assign count_en = accept && (!mask_enable_reg || pixel_in.mask_value != 8'd0);

    always_comb
    begin
        total_next = total_reg;
        if (state_reg == mhms_pkg::ST_EMIT)
        begin
            total_next = '0;
        end
        else if (count_en && total_reg != '1)
        begin
            total_next = total_reg + 1'b1;
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mhms_pkg::ST_CLEAR:
            begin
                if (walk_reg == mhms_pkg::WALK_BITS'(mhms_pkg::BIN_COUNT - 1))
                begin
                    state_next = mhms_pkg::ST_IDLE;
                end
            end
            mhms_pkg::ST_IDLE:
            begin
                if (accept && pixel_in.last_pixel)
                begin
                    state_next = mhms_pkg::ST_DRAIN;
                end
            end
            mhms_pkg::ST_DRAIN:
            begin
                state_next = mhms_pkg::ST_SUM;
            end
            mhms_pkg::ST_SUM:
            begin
                if (sum_done)
                begin
                    state_next = (s_reg == '0) ? mhms_pkg::ST_EMIT : mhms_pkg::ST_MEAN_GO;
                end
            end
            mhms_pkg::ST_MEAN_GO:
            begin
                state_next = mhms_pkg::ST_MEAN;
            end
            mhms_pkg::ST_MEAN:
            begin
                if (div_rsp.done)
                begin
                    state_next = mhms_pkg::ST_VAR;
                end
            end
            mhms_pkg::ST_VAR:
            begin
                if (var_done)
                begin
                    state_next = mhms_pkg::ST_ROOT_GO;
                end
            end
            mhms_pkg::ST_ROOT_GO:
            begin
                state_next = mhms_pkg::ST_ROOT;
            end
            mhms_pkg::ST_ROOT:
            begin
                if (sqrt_rsp.done)
                begin
                    state_next = mhms_pkg::ST_SPREAD_GO;
                end
            end
            mhms_pkg::ST_SPREAD_GO:
            begin
                state_next = mhms_pkg::ST_SPREAD;
            end
            mhms_pkg::ST_SPREAD:
            begin
                if (div_rsp.done)
                begin
                    state_next = mhms_pkg::ST_EMIT;
                end
            end
            mhms_pkg::ST_EMIT:
            begin
                state_next = mhms_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mhms_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb
    begin
        busy        = 1'b1;
        stats_valid = 1'b0;
        div_go      = 1'b0;
        sqrt_go     = 1'b0;
        walk_issue  = 1'b0;
        clear_we    = 1'b0;
        unique case (state_reg)
            mhms_pkg::ST_IDLE:      busy        = 1'b0;
            mhms_pkg::ST_CLEAR:     clear_we    = 1'b1;
            mhms_pkg::ST_SUM:       walk_issue  = walk_reg < mhms_pkg::WALK_BITS'(mhms_pkg::BIN_COUNT);
            mhms_pkg::ST_VAR:       walk_issue  = walk_reg < mhms_pkg::WALK_BITS'(mhms_pkg::BIN_COUNT);
            mhms_pkg::ST_MEAN_GO:   div_go      = 1'b1;
            mhms_pkg::ST_SPREAD_GO: div_go      = 1'b1;
            mhms_pkg::ST_ROOT_GO:   sqrt_go     = 1'b1;
            mhms_pkg::ST_EMIT:      stats_valid = 1'b1;
            default:                busy        = 1'b1;
        endcase
    end

    assign sum_done = !walk_issue && !rd_v_reg;
    assign var_done = !walk_issue && !rd_v_reg && !v2_reg && !v3_reg;

    // ---------------- histogram RAM ----------------
    // forward the last write when the pixel just read hits the same bin
    assign bin_old = (lw_valid_reg && lw_addr_reg == s1_addr_reg) ? lw_data_reg : ram_rdata;
    assign bin_new = (bin_old == '1) ? bin_old : bin_old + 1'b1;

    always_comb
    begin
        ram_raddr = (state_reg == mhms_pkg::ST_IDLE) ? pixel_in.pixel_value : walk_reg[BB-1:0];
        ram_we    = 1'b0;
        ram_waddr = s1_addr_reg;
        ram_wdata = bin_new;
        if (s1_valid_reg)
        begin
            ram_we = 1'b1;
        end
        else if (clear_we || (state_reg == mhms_pkg::ST_VAR && walk_issue))
        begin
            // zero each bin after reset, and as it is read for the last time this frame
            ram_we    = 1'b1;
            ram_waddr = walk_reg[BB-1:0];
            ram_wdata = '0;
        end
    end

    mhms_ram #(
        .WIDTH (CB),
        .DEPTH (mhms_pkg::BIN_COUNT)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- arithmetic units ----------------
    always_comb
    begin
        div_req.start = div_go;
        div_req.den   = {s_reg, 1'b0};
        if (state_reg == mhms_pkg::ST_SPREAD_GO)
        begin
            div_req.num = mhms_pkg::DIVN_BITS'(root_reg) + mhms_pkg::DIVN_BITS'(s_reg);
        end
        else
        begin
            div_req.num = {w_reg, 1'b0} + mhms_pkg::DIVN_BITS'(s_reg);
        end
        sqrt_req.start = sqrt_go;
        sqrt_req.value = {v_reg, 2'b00};
    end

    mhms_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mhms_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    assign dev = ({1'b0, rd_k_reg} >= {1'b0, mean_reg}) ? 8'(rd_k_reg - mean_reg)
                                                         : 8'(mean_reg - rd_k_reg);

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mhms_pkg::ST_CLEAR;
            total_reg    <= '0;
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            rd_v_reg     <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            walk_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            s1_valid_reg <= count_en;
            lw_valid_reg <= s1_valid_reg;
            rd_v_reg     <= walk_issue;
            v2_reg       <= rd_v_reg && state_reg == mhms_pkg::ST_VAR;
            v3_reg       <= v2_reg;
            if (walk_issue || clear_we)
            begin
                walk_reg <= walk_reg + 1'b1;
            end
            else if (state_reg != mhms_pkg::ST_SUM && state_reg != mhms_pkg::ST_VAR)
            begin
                walk_reg <= '0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        s1_addr_reg <= pixel_in.pixel_value;
        lw_addr_reg <= s1_addr_reg;
        lw_data_reg <= bin_new;
        rd_k_reg    <= walk_reg[BB-1:0];
        t_reg       <= mhms_pkg::DEV_BITS'(ram_rdata) * mhms_pkg::DEV_BITS'(dev);
        tt_reg      <= t_reg * t_reg;
        if (state_reg == mhms_pkg::ST_DRAIN)
        begin
            s_reg      <= '0;
            w_reg      <= '0;
            v_reg      <= '0;
            mean_reg   <= '0;
            spread_reg <= '0;
        end
        else
        begin
            if (rd_v_reg && state_reg == mhms_pkg::ST_SUM)
            begin
                s_reg <= s_reg + mhms_pkg::SUM_BITS'(ram_rdata);
                w_reg <= w_reg + mhms_pkg::WSUM_BITS'(ram_rdata)
                               * mhms_pkg::WSUM_BITS'(rd_k_reg);
            end
            if (v3_reg)
            begin
                v_reg <= v_reg + mhms_pkg::VAR_BITS'(tt_reg);
            end
            if (state_reg == mhms_pkg::ST_MEAN && div_rsp.done)
            begin
                mean_reg <= div_rsp.quot;
            end
            if (state_reg == mhms_pkg::ST_SPREAD && div_rsp.done)
            begin
                spread_reg <= div_rsp.quot;
            end
        end
        if (sqrt_rsp.done)
        begin
            root_reg <= sqrt_rsp.root;
        end
    end

    // ---------------- result transaction ----------------
    assign total_ext = mhms_pkg::CMP_BITS'(total_reg);

    always_comb
    begin
        stats_out.mean_level  = mean_reg;
        stats_out.spread      = spread_reg;
        stats_out.empty_frame = (s_reg == '0);
        if (total_ext > mhms_pkg::CMP_BITS'({mhms_pkg::OUT_CNT_BITS{1'b1}}))
        begin
            stats_out.pixel_count = '1;
        end
        else
        begin
            stats_out.pixel_count = total_ext[mhms_pkg::OUT_CNT_BITS-1:0];
        end
    end

    // ---------------- assertions ----------------
    `MHMS_ASSERT_NXT(a_last_goes_busy, clk, rst_n, accept && pixel_in.last_pixel, busy)
    `MHMS_ASSERT_NXT(a_strobe_single, clk, rst_n, stats_valid, !stats_valid && !busy)
    `MHMS_ASSERT_IMP(a_empty_zero, clk, rst_n, stats_valid && stats_out.empty_frame,
                     stats_out.mean_level == 8'd0 && stats_out.spread == 8'd0)
    `MHMS_ASSERT_IMP(a_no_count_in_walk, clk, rst_n, busy,
                     !s1_valid_reg || state_reg == mhms_pkg::ST_DRAIN)
endmodule
